// ----- hw/rtl/dmr_pkg.sv -----
// Shared types and constants for the dual motor ramp H-bridge drive.
// No dependencies; imported by every module of the block.
package dmr_pkg;

  localparam int DUTY_BITS  = 8;
  localparam int LEVEL_BITS = 16;
  localparam int REG_BITS   = 8;
  localparam int IDX_BITS   = 1;

  localparam logic [IDX_BITS-1:0] REG_RAMP_STEP = 1'b0;
  localparam logic [IDX_BITS-1:0] REG_MAX_DUTY  = 1'b1;

  localparam logic [REG_BITS-1:0] RAMP_STEP_RST = 8'd2;
  localparam logic [REG_BITS-1:0] MAX_DUTY_RST  = 8'd255;

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef logic signed [LEVEL_BITS-1:0] level_t;
  typedef logic [DUTY_BITS-1:0]         duty_t;

  typedef struct packed {
    level_t level;
    duty_t  fwd;
    duty_t  rev;
  } lane_res_t;

  function automatic duty_t duty_mask(input logic [REG_BITS-1:0] v);
    logic [15:0] w;
    w = {8'd0, v};
    return w[DUTY_BITS-1:0];
  endfunction

endpackage

// ----- hw/rtl/dmr_lane.sv -----
// One motor lane: level and goal registers, snap on set, ramp on tick,
// and bridge duty mapping of the new level. Depends on dmr_pkg.
module dmr_lane import dmr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                cmd,
  input  level_t              target,
  input  logic [REG_BITS-1:0] ramp_step,
  input  logic [REG_BITS-1:0] max_duty,
  output lane_res_t           res
);

  level_t now_r, now_nxt;
  level_t goal_r, goal_nxt;
  level_t ramped;
  level_t snapped;
  logic signed [LEVEL_BITS+1:0] now_w, goal_w, up_w, dn_w;
  logic [LEVEL_BITS:0] mag;
  logic [REG_BITS-1:0] sat;

  always_comb begin
    now_w  = {{2{now_r[LEVEL_BITS-1]}}, now_r};
    goal_w = {{2{goal_r[LEVEL_BITS-1]}}, goal_r};
    up_w   = now_w + $signed({2'b00, {(LEVEL_BITS-REG_BITS){1'b0}}, ramp_step});
    dn_w   = now_w - $signed({2'b00, {(LEVEL_BITS-REG_BITS){1'b0}}, ramp_step});
    priority if (goal_r > now_r) begin
      ramped = (up_w > goal_w) ? goal_r : up_w[LEVEL_BITS-1:0];
    end else if (goal_r < now_r) begin
      ramped = (dn_w < goal_w) ? goal_r : dn_w[LEVEL_BITS-1:0];
    end else begin
      ramped = now_r;
    end
  end

  always_comb begin
    priority if (now_r > 0 && target < now_r) begin
      snapped = (target > 0) ? target : '0;
    end else if (now_r < 0 && target > now_r) begin
      snapped = (target < 0) ? target : '0;
    end else begin
      snapped = now_r;
    end
  end

  always_comb begin
    now_nxt  = now_r;
    goal_nxt = goal_r;
    if (accept) begin
      if (cmd == CMD_TICK) begin
        now_nxt = ramped;
      end else begin
        now_nxt  = snapped;
        goal_nxt = target;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r  <= '0;
      goal_r <= '0;
    end else begin
      now_r  <= now_nxt;
      goal_r <= goal_nxt;
    end
  end

  always_comb begin
    mag = ramped[LEVEL_BITS-1] ? (LEVEL_BITS+1)'(-{ramped[LEVEL_BITS-1], ramped})
                               : {1'b0, ramped};
    sat = (mag > {{(LEVEL_BITS+1-REG_BITS){1'b0}}, max_duty}) ? max_duty
                                                              : mag[REG_BITS-1:0];
    res.level = ramped;
    if (ramped == 0) begin
      res.fwd = duty_mask(max_duty);
      res.rev = duty_mask(max_duty);
    end else if (ramped[LEVEL_BITS-1]) begin
      res.fwd = '0;
      res.rev = duty_mask(sat);
    end else begin
      res.fwd = duty_mask(sat);
      res.rev = '0;
    end
  end

endmodule

// ----- hw/rtl/dmr_merge.sv -----
// Output register: merges both lane results into one result word and
// holds it until taken. Depends on dmr_pkg.
module dmr_merge import dmr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  lane_res_t first_res,
  input  lane_res_t second_res,
  input  logic      out_ready,
  output logic      out_valid,
  output logic      can_load,
  output lane_res_t first_q,
  output lane_res_t second_q
);

  logic      valid_r, valid_nxt;
  lane_res_t first_r, second_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      first_r  <= first_res;
      second_r <= second_res;
    end
  end

  assign out_valid = valid_r;
  assign first_q   = first_r;
  assign second_q  = second_r;

endmodule

// ----- hw/rtl/dual_motor_ramp_hbridge_drive.sv -----
// Top level of the dual motor ramp H-bridge drive.
// Depends on dmr_pkg, dmr_lane and dmr_merge.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per command. cmd set
//   stores both signed targets and may snap a level toward zero; it yields
//   no result. cmd tick ramps both levels by ramp_step toward their targets
//   and yields one result word on the out_ channel: four bridge duties and
//   the two new levels.
//   A tick result is registered and is valid the cycle after the tick is accepted.
//   Throughput: one word per cycle while the output is not stalled; both motors are handled by
//   two lanes in the same cycle and a single output register joins their results.
//   Stall: the output register holds a result until out_ready; in_ready is
//   high while that register is empty or being emptied, so a stalled
//   receiver stops input after one pending result.
//   Reset (rst_n low, synchronous): levels and targets clear to zero,
//   ramp_step returns to 2, max_duty to 255, no result pending.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index (0 ramp_step,
//   1 max_duty) at the clock edge; write only while the block is idle.
module dual_motor_ramp_hbridge_drive import dmr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  level_t              in_target_first,
  input  level_t              in_target_second,
  output logic                out_valid,
  input  logic                out_ready,
  output duty_t               out_first_duty_fwd,
  output duty_t               out_first_duty_rev,
  output duty_t               out_second_duty_fwd,
  output duty_t               out_second_duty_rev,
  output level_t              out_first_level,
  output level_t              out_second_level
);

  logic [REG_BITS-1:0] ramp_step_r, ramp_step_nxt;
  logic [REG_BITS-1:0] max_duty_r, max_duty_nxt;
  logic      accept;
  logic      can_load;
  lane_res_t first_res, second_res, first_q, second_q;

  always_comb begin
    ramp_step_nxt = ramp_step_r;
    max_duty_nxt  = max_duty_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_RAMP_STEP: ramp_step_nxt = cfg_wdata;
        REG_MAX_DUTY:  max_duty_nxt  = cfg_wdata;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_step_r <= RAMP_STEP_RST;
      max_duty_r  <= MAX_DUTY_RST;
    end else begin
      ramp_step_r <= ramp_step_nxt;
      max_duty_r  <= max_duty_nxt;
    end
  end

  assign in_ready = can_load;
  assign accept   = in_valid && can_load;

  dmr_lane u_lane_first (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cmd       (in_cmd),
    .target    (in_target_first),
    .ramp_step (ramp_step_r),
    .max_duty  (max_duty_r),
    .res       (first_res)
  );

  dmr_lane u_lane_second (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cmd       (in_cmd),
    .target    (in_target_second),
    .ramp_step (ramp_step_r),
    .max_duty  (max_duty_r),
    .res       (second_res)
  );

  dmr_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept && in_cmd == CMD_TICK),
    .first_res  (first_res),
    .second_res (second_res),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .can_load   (can_load),
    .first_q    (first_q),
    .second_q   (second_q)
  );

  assign out_first_duty_fwd  = first_q.fwd;
  assign out_first_duty_rev  = first_q.rev;
  assign out_second_duty_fwd = second_q.fwd;
  assign out_second_duty_rev = second_q.rev;
  assign out_first_level     = first_q.level;
  assign out_second_level    = second_q.level;

endmodule

// ----- tb/tb_dual_motor_ramp_hbridge_drive.sv -----
// Self-checking testbench for the dual motor ramp H-bridge drive.
// Depends on dmr_pkg and dual_motor_ramp_hbridge_drive; predicts every tick word
// from its own copy of levels, targets and registers and checks it on the out_ channel.
module tb_dual_motor_ramp_hbridge_drive;
  import dmr_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct {
    duty_t  first_fwd;
    duty_t  first_rev;
    duty_t  second_fwd;
    duty_t  second_rev;
    level_t first_lvl;
    level_t second_lvl;
  } drive_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [IDX_BITS-1:0] cfg_index = '0;
  logic [REG_BITS-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_cmd = CMD_SET;
  level_t              in_target_first = '0;
  level_t              in_target_second = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  duty_t               out_first_duty_fwd;
  duty_t               out_first_duty_rev;
  duty_t               out_second_duty_fwd;
  duty_t               out_second_duty_rev;
  level_t              out_first_level;
  level_t              out_second_level;

  int lane_level[2];
  int lane_goal[2];
  int step_reg;
  int duty_cap;

  drive_word_t pending_words[$];
  int          faults;
  int          stall_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;

  dual_motor_ramp_hbridge_drive dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_target_first     (in_target_first),
    .in_target_second    (in_target_second),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_first_duty_fwd  (out_first_duty_fwd),
    .out_first_duty_rev  (out_first_duty_rev),
    .out_second_duty_fwd (out_second_duty_fwd),
    .out_second_duty_rev (out_second_duty_rev),
    .out_first_level     (out_first_level),
    .out_second_level    (out_second_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void aim_lane(input int m, input int tgt);
    lane_goal[m] = tgt;
    if (lane_level[m] > 0 && tgt < lane_level[m]) begin
      lane_level[m] = (tgt > 0) ? tgt : 0;
    end else if (lane_level[m] < 0 && tgt > lane_level[m]) begin
      lane_level[m] = (tgt < 0) ? tgt : 0;
    end
  endfunction

  function automatic void ramp_lane(input int m);
    int nxt;
    if (lane_goal[m] > lane_level[m]) begin
      nxt = lane_level[m] + step_reg;
      lane_level[m] = (nxt > lane_goal[m]) ? lane_goal[m] : nxt;
    end else if (lane_goal[m] < lane_level[m]) begin
      nxt = lane_level[m] - step_reg;
      lane_level[m] = (nxt < lane_goal[m]) ? lane_goal[m] : nxt;
    end
  endfunction

  function automatic void bridge_duty(input int lvl, output duty_t fwd, output duty_t rev);
    int mag;
    if (lvl == 0) begin
      fwd = duty_t'(duty_cap);
      rev = duty_t'(duty_cap);
      return;
    end
    mag = (lvl < 0) ? -lvl : lvl;
    if (mag > duty_cap) mag = duty_cap;
    if (lvl < 0) begin
      fwd = '0;
      rev = duty_t'(mag);
    end else begin
      fwd = duty_t'(mag);
      rev = '0;
    end
  endfunction

  function automatic void predict_drive(input logic cmd, input level_t t1, input level_t t2);
    drive_word_t w;
    if (cmd == CMD_SET) begin
      aim_lane(0, int'(t1));
      aim_lane(1, int'(t2));
    end else begin
      ramp_lane(0);
      ramp_lane(1);
      bridge_duty(lane_level[0], w.first_fwd, w.first_rev);
      bridge_duty(lane_level[1], w.second_fwd, w.second_rev);
      w.first_lvl  = level_t'(lane_level[0]);
      w.second_lvl = level_t'(lane_level[1]);
      pending_words.push_back(w);
    end
  endfunction

  function automatic level_t pick_target();
    case ($urandom_range(9))
      0, 1: return level_t'($urandom);
      2: begin
        case ($urandom_range(4))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sd0;
          3: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      default: return level_t'(int'($urandom_range(1200)) - 600);
    endcase
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_words
    drive_word_t want;
    drive_word_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen.first_fwd  = out_first_duty_fwd;
      seen.first_rev  = out_first_duty_rev;
      seen.second_fwd = out_second_duty_fwd;
      seen.second_rev = out_second_duty_rev;
      seen.first_lvl  = out_first_level;
      seen.second_lvl = out_second_level;
      if (pending_words.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected drive word: fwd/rev %0d/%0d %0d/%0d lvl %0d %0d",
                   seen.first_fwd, seen.first_rev, seen.second_fwd, seen.second_rev,
                   seen.first_lvl, seen.second_lvl);
      end else begin
        want = pending_words.pop_front();
        if (want.first_fwd !== seen.first_fwd || want.first_rev !== seen.first_rev ||
            want.second_fwd !== seen.second_fwd || want.second_rev !== seen.second_rev ||
            want.first_lvl !== seen.first_lvl || want.second_lvl !== seen.second_lvl) begin
          faults++;
          if (faults <= 10)
            $display({"drive word mismatch: exp %0d/%0d %0d/%0d lvl %0d %0d, ",
                      "got %0d/%0d %0d/%0d lvl %0d %0d"},
                     want.first_fwd, want.first_rev, want.second_fwd, want.second_rev,
                     want.first_lvl, want.second_lvl,
                     seen.first_fwd, seen.first_rev, seen.second_fwd, seen.second_rev,
                     seen.first_lvl, seen.second_lvl);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // enter and leave at a falling edge; valid stays high until the next word or a pause
  task automatic drive_word(input logic cmd, input level_t t1, input level_t t2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_target_first  <= t1;
    in_target_second <= t2;
    do @(posedge clk); while (!in_ready);
    predict_drive(cmd, t1, t2);
    @(negedge clk);
  endtask

  task automatic tick();
    drive_word(CMD_TICK, level_t'($urandom), level_t'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_RAMP_STEP) step_reg = int'(val);
    else duty_cap = int'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_brake();
    tick();
  endtask

  task automatic test_ramp_saturate();
    write_reg(REG_RAMP_STEP, 8'd255);
    drive_word(CMD_SET, 16'sd1000, -16'sd1000);
    repeat (5) tick();
  endtask

  task automatic test_snap();
    drive_word(CMD_SET, 16'sd300, -16'sd300);
    tick();
    drive_word(CMD_SET, -16'sd50, 16'sd50);
    tick();
    tick();
    drive_word(CMD_SET, 16'sd0, 16'sd0);
    tick();
  endtask

  task automatic test_zero_regs();
    write_reg(REG_RAMP_STEP, 8'd1);
    drive_word(CMD_SET, 16'sd200, -16'sd200);
    repeat (3) tick();
    write_reg(REG_MAX_DUTY, 8'd0);
    tick();
    write_reg(REG_RAMP_STEP, 8'd0);
    tick();
    drive_word(CMD_SET, 16'sd1, -16'sd1);
    tick();
    drive_word(CMD_SET, 16'sd0, 16'sd0);
    tick();
  endtask

  task automatic test_full_scale();
    write_reg(REG_RAMP_STEP, 8'd255);
    write_reg(REG_MAX_DUTY, 8'd255);
    drive_word(CMD_SET, 16'sh7FFF, 16'sh8000);
    repeat (131) tick();
    write_reg(REG_MAX_DUTY, 8'd1);
    drive_word(CMD_SET, 16'sh8000, 16'sh7FFF);
    repeat (131) tick();
  endtask

  task automatic test_random_traffic(input int n_items, input int s_idle, input int r_idle);
    logic [REG_BITS-1:0] val;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        for (int r = 0; r < 2; r++) begin
          case ($urandom_range(3))
            0: val = 8'd0;
            1: val = 8'd1;
            2: val = 8'd255;
            default: val = REG_BITS'($urandom);
          endcase
          write_reg((r == 0) ? REG_RAMP_STEP : REG_MAX_DUTY, val);
        end
      end
      if ($urandom_range(49) == 0) wait_idle();
      if ($urandom_range(99) < 65) tick();
      else drive_word(CMD_SET, pick_target(), pick_target());
    end
  endtask

  initial begin
    lane_level[0] = 0;
    lane_level[1] = 0;
    lane_goal[0]  = 0;
    lane_goal[1]  = 0;
    step_reg      = int'(RAMP_STEP_RST);
    duty_cap      = int'(MAX_DUTY_RST);
    faults        = 0;
    send_idle_pct = 9;
    recv_idle_pct = 86;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_brake();
    test_ramp_saturate();
    test_snap();
    test_zero_regs();
    test_full_scale();
    test_random_traffic(170, 9, 86);
    test_random_traffic(170, 86, 9);
    test_random_traffic(170, 0, 0);
    wait_idle();
    if (faults == 0 && pending_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
